// ===== hdl/sitda_pkg.sv =====
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared constants for the signed integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

   localparam int VALUE_W   = 32;
   localparam int DIGIT_W   = 4;
   localparam int CHAR_W    = 6;
   localparam int COUNT_W   = 4;
   localparam int MAX_DIGITS = 10;

   // ceil(2^35 / 10): exact quotient for every 32-bit unsigned dividend
   localparam logic [VALUE_W-1:0] RADIX_RECIP = 32'hCCCC_CCCD;
   localparam int                 RECIP_SHIFT = 35;

   localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 6'd48;
   localparam logic [CHAR_W-1:0]  ASCII_MINUS = 6'd45;

   localparam logic [COUNT_W-1:0] LAST_DIGIT_IDX = COUNT_W'(MAX_DIGITS - 1);

endpackage

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer into its decimal ASCII text, one
// character per output beat, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one beat carries req_value (two's complement). The block
//   takes a beat only when idle, so req_stall is high from acceptance until
//   the final character has been taken.
//   rsp channel: one beat per character: '-' first for a negative value,
//   then the digits without leading zeros; rsp_last marks the final one.
//   Zero gives a single '0'; the most negative value gives -2147483648.
// Sequencing:
//   Digits come from a single divide-by-ten unit, each digit taking a
//   reciprocal multiply (ST_MUL), then quotient/remainder (ST_DIV). The
//   first character is registered when the top digit is produced, and the
//   block takes a new request only after the last character is taken.
// Reset: synchronous, active high; returns to idle with no output beat.
// A stalled receiver holds the current character in the output register.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [sitda_pkg::VALUE_W-1:0]   req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [sitda_pkg::CHAR_W-1:0]           rsp_character,
   output logic                                   rsp_last
);
   import sitda_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_EMIT
   } state_type;

   state_type            state_ff;
   logic [VALUE_W-1:0]   mag_ff;
   logic                 neg_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]   idx_ff;
   logic                 rsp_valid_ff;
   logic [CHAR_W-1:0]    rsp_character_ff;
   logic                 rsp_last_ff;

   logic [DIGIT_W-1:0]   digit_store [MAX_DIGITS];

   logic [VALUE_W-1:0]   raw_value;
   logic [VALUE_W-1:0]   mag_in;
   logic [VALUE_W-1:0]   quotient;
   logic [DIGIT_W-1:0]   remainder;
   logic                 req_beat;

   assign raw_value = VALUE_W'(unsigned'(req_value));
   assign mag_in    = raw_value[VALUE_W-1] ? (VALUE_W'(0) - raw_value) : raw_value;
   assign req_beat  = req_valid && !req_stall;

   // shared divide-by-ten unit
   sitda_div10 u_div10 (
      .clock      (clock),
      .mul_enable (state_ff == ST_MUL),
      .operand    (mag_ff),
      .quotient   (quotient),
      .remainder  (remainder)
   );

   // digit store, least significant first
   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV) begin
         digit_store[count_ff] <= remainder;
      end
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         neg_ff       <= 1'b0;
         count_ff     <= '0;
         idx_ff       <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_beat) begin
                  neg_ff   <= raw_value[VALUE_W-1];
                  mag_ff   <= mag_in;
                  count_ff <= '0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               mag_ff   <= quotient;
               count_ff <= count_ff + COUNT_W'(1);
               if (quotient == '0 || count_ff == LAST_DIGIT_IDX) begin
                  // top digit is the one just produced
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_EMIT;
                  if (neg_ff) begin
                     rsp_character_ff <= ASCII_MINUS;
                     rsp_last_ff      <= 1'b0;
                     idx_ff           <= count_ff;
                  end else begin
                     rsp_character_ff <= ASCII_ZERO + CHAR_W'(remainder);
                     rsp_last_ff      <= (count_ff == '0);
                     idx_ff           <= count_ff - COUNT_W'(1);
                  end
               end else begin
                  state_ff <= ST_MUL;
               end
            end
            ST_EMIT: begin
               if (!rsp_stall) begin
                  if (rsp_last_ff) begin
                     rsp_valid_ff <= 1'b0;
                     state_ff     <= ST_IDLE;
                  end else begin
                     rsp_character_ff <= ASCII_ZERO + CHAR_W'(digit_store[idx_ff]);
                     rsp_last_ff      <= (idx_ff == '0);
                     idx_ff           <= idx_ff - COUNT_W'(1);
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// ===== hdl/sitda_div10.sv =====
// ----------------------------------------------------------------------------
// sitda_div10
// Shared divide-by-ten unit. A registered reciprocal multiply, followed by a
// quotient extract and remainder subtract in the next cycle.
// ----------------------------------------------------------------------------
module sitda_div10 (
   input  logic                            clock,
   input  logic                            mul_enable,
   input  logic [sitda_pkg::VALUE_W-1:0]   operand,
   output logic [sitda_pkg::VALUE_W-1:0]   quotient,
   output logic [sitda_pkg::DIGIT_W-1:0]   remainder
);
   import sitda_pkg::*;

   logic [2*VALUE_W-1:0] prod_ff;
   logic [2*VALUE_W-1:0] prod_in;
   logic [VALUE_W-1:0]   times_ten;
   logic [VALUE_W-1:0]   diff;

   // multiply by the reciprocal; operand must hold until the next cycle
   assign prod_in = {{VALUE_W{1'b0}}, operand} * {{VALUE_W{1'b0}}, RADIX_RECIP};

   always_ff @(posedge clock) begin
      if (mul_enable) begin
         prod_ff <= prod_in;
      end
   end

   // q = prod >> 35, r = operand - 10q (fits in four bits)
   assign quotient  = VALUE_W'(prod_ff[2*VALUE_W-1:RECIP_SHIFT]);
   assign times_ten = {quotient[VALUE_W-4:0], 3'b000} + {quotient[VALUE_W-2:0], 1'b0};
   assign diff      = operand - times_ten;
   assign remainder = diff[DIGIT_W-1:0];

endmodule
